@@ design/prewitt_edge_magnitude_3x3_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Prewitt edge unit assertion macros
// Concurrent checks used by the Prewitt edge magnitude unit.
// ----------------------------------------------------------------------------
`ifndef PREWITT_EDGE_MAGNITUDE_3X3_UNIT_ASSERT_SVH
`define PREWITT_EDGE_MAGNITUDE_3X3_UNIT_ASSERT_SVH

// same-cycle implication, masked during reset
`define PREWITT_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define PREWITT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/prewitt_pkg.sv @@
// ----------------------------------------------------------------------------
// Prewitt edge package
// Pixel, line store and gradient types, register codes and clamp helper.
// ----------------------------------------------------------------------------
package prewitt_pkg;

    localparam int PIXEL_BITS      = 8;
    localparam int CFG_INDEX_BITS  = 8;
    localparam int CFG_DATA_BITS   = 13;
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int ROW_BITS        = 12;
    localparam int GRAD_BITS       = 11;

    localparam int MIN_DIM      = 3;
    localparam int HEIGHT_MAX   = 4096;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    typedef logic [PIXEL_BITS-1:0]       pixel_t;
    typedef logic signed [GRAD_BITS-1:0] grad_t;

    localparam pixel_t PIX_MAX      = PIXEL_BITS'(255);
    localparam grad_t  GRAD_PIX_MAX = GRAD_BITS'(255);

    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_HEIGHT = CFG_INDEX_BITS'(1);

    // one line store column: two rows above the incoming pixel
    typedef struct packed {
        pixel_t top;
        pixel_t mid;
    } line_word_t;

    function automatic pixel_t clamp_grad(grad_t g);
        pixel_t res;
        if (g[GRAD_BITS-1]) begin
            res = '0;
        end else if (g > GRAD_PIX_MAX) begin
            res = PIX_MAX;
        end else begin
            res = g[PIXEL_BITS-1:0];
        end
        return res;
    endfunction

endpackage

@@ design/prewitt_edge_magnitude_3x3_unit.sv @@
// ----------------------------------------------------------------------------
// Prewitt edge magnitude 3x3 unit
// Streams raster pixels through a two-line store and a 3x3 window and emits
// the clamped sum of the clamped vertical and horizontal Prewitt gradients.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock unless the output stalls, and returns one edge
// word per interior pixel: first the line store RAM is read into a register,
// then the window shifts and the result is registered. Border rows and columns
// produce no word; m_frame_last marks the final interior pixel of a frame. A
// write to either size register restarts the frame. The line store has no
// clearing pass; rows 0 and 1 of a frame fill it.
`include "prewitt_edge_magnitude_3x3_unit_assert.svh"

module prewitt_edge_magnitude_3x3_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  prewitt_pkg::pixel_t                  s_pixel_value,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output prewitt_pkg::pixel_t                  m_edge_value,
    output logic                                 m_frame_last,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [prewitt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [prewitt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import prewitt_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int RESET_W  = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

    typedef logic [COL_BITS-1:0] col_t;
    typedef logic [ROW_BITS-1:0] row_t;

    // configuration
    col_t        width_m1_reg, width_m1_next;
    row_t        height_m1_reg, height_m1_next;
    logic        cfg_wr, cfg_hit;
    logic [31:0] cfg_w, cfg_h;

    // counters
    col_t col_reg, col_next;
    row_t row_reg, row_next;
    logic col_last, row_last, s_accept;

    // read stage
    logic       s1_valid_reg, s1_valid_next;
    pixel_t     s1_pixel_reg;
    col_t       s1_col_reg;
    logic       s1_emit_reg, s1_last_reg;
    line_word_t s1_word_reg;
    line_word_t line_mem [MAX_WIDTH];
    logic       advance;

    // window and result
    pixel_t                win_reg [3][3];
    grad_t                 left_sum, right_sum, upper_sum, lower_sum, grad_v, grad_h;
    logic [PIXEL_BITS:0]   edge_sum;
    pixel_t                edge_value;
    logic                  m_valid_reg, m_valid_next;
    pixel_t                m_edge_reg;
    logic                  m_last_reg;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_wr && (cfg_index == CFG_IDX_WIDTH || cfg_index == CFG_IDX_HEIGHT);
    assign cfg_w     = 32'(cfg_data[WIDTH_REG_BITS-1:0]);
    assign cfg_h     = 32'(cfg_data[HEIGHT_REG_BITS-1:0]);

    always_comb begin
        width_m1_next  = width_m1_reg;
        height_m1_next = height_m1_reg;
        if (cfg_wr && cfg_index == CFG_IDX_WIDTH) begin
            if (cfg_w < 32'(MIN_DIM)) begin
                width_m1_next = COL_BITS'(MIN_DIM - 1);
            end else if (cfg_w > 32'(MAX_WIDTH)) begin
                width_m1_next = COL_BITS'(MAX_WIDTH - 1);
            end else begin
                width_m1_next = COL_BITS'(cfg_w - 32'd1);
            end
        end
        if (cfg_wr && cfg_index == CFG_IDX_HEIGHT) begin
            if (cfg_h < 32'(MIN_DIM)) begin
                height_m1_next = ROW_BITS'(MIN_DIM - 1);
            end else if (cfg_h > 32'(HEIGHT_MAX)) begin
                height_m1_next = ROW_BITS'(HEIGHT_MAX - 1);
            end else begin
                height_m1_next = ROW_BITS'(cfg_h - 32'd1);
            end
        end
    end

    assign advance  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || advance;
    assign s_accept = s_valid && s_ready;
    assign col_last = (col_reg == width_m1_reg);
    assign row_last = (row_reg == height_m1_reg);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit) begin
            col_next = '0;
            row_next = '0;
        end else if (s_accept) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + row_t'(1);
            end else begin
                col_next = col_reg + col_t'(1);
            end
        end
    end

    assign s1_valid_next = s_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);

    // gradients over the window after this shift
    assign left_sum  = grad_t'(win_reg[0][1]) + grad_t'(win_reg[1][1]) + grad_t'(win_reg[2][1]);
    assign right_sum = grad_t'(s1_word_reg.top) + grad_t'(s1_word_reg.mid)
                     + grad_t'(s1_pixel_reg);
    assign upper_sum = grad_t'(win_reg[0][1]) + grad_t'(win_reg[0][2])
                     + grad_t'(s1_word_reg.top);
    assign lower_sum = grad_t'(win_reg[2][1]) + grad_t'(win_reg[2][2]) + grad_t'(s1_pixel_reg);
    assign grad_v    = lower_sum - upper_sum;
    assign grad_h    = right_sum - left_sum;
    assign edge_sum  = {1'b0, clamp_grad(grad_v)} + {1'b0, clamp_grad(grad_h)};
    assign edge_value = edge_sum[PIXEL_BITS] ? PIX_MAX : edge_sum[PIXEL_BITS-1:0];

    assign m_valid_next = advance ? s1_emit_reg : (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_m1_reg  <= COL_BITS'(RESET_W - 1);
            height_m1_reg <= ROW_BITS'(RESET_HEIGHT - 1);
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else begin
            width_m1_reg  <= width_m1_next;
            height_m1_reg <= height_m1_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= s1_valid_next;
            m_valid_reg   <= m_valid_next;
            if (advance) begin
                for (int i = 0; i < 3; i++) begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= s1_word_reg.top;
                win_reg[1][2] <= s1_word_reg.mid;
                win_reg[2][2] <= s1_pixel_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_word_reg  <= line_mem[col_reg];
            s1_pixel_reg <= s_pixel_value;
            s1_col_reg   <= col_reg;
            s1_emit_reg  <= (row_reg >= row_t'(2)) && (col_reg >= col_t'(2));
            s1_last_reg  <= row_last && col_last;
        end
        if (advance) begin
            line_mem[s1_col_reg] <= '{top: s1_word_reg.mid, mid: s1_pixel_reg};
            m_edge_reg           <= edge_value;
            m_last_reg           <= s1_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_edge_value = m_edge_reg;
    assign m_frame_last = m_last_reg;

    `PREWITT_ASSERT_IMPLY(a_col_in_range, aclk, aresetn, 1'b1, col_reg <= width_m1_reg, "column count beyond row width")
    `PREWITT_ASSERT_IMPLY(a_row_in_range, aclk, aresetn, 1'b1, row_reg <= height_m1_reg, "row count beyond frame height")
    `PREWITT_ASSERT_NEXT(a_cfg_restart, aclk, aresetn, cfg_hit, (col_reg == '0) && (row_reg == '0), "frame not restarted after size write")
    `PREWITT_ASSERT_NEXT(a_emit_delivers, aclk, aresetn, advance && s1_emit_reg, m_valid_reg, "interior pixel lost its result")

endmodule
